@@ src/tlbsa_pkg.sv @@
// Shared types and constants for the two-level bitmap slot allocator.
// Holds the transfer payload structs, command, status and register index codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlbsa_pkg;

  // Default map geometry
  localparam int MAP_WORDS_DEF     = 32;
  localparam int BITS_PER_WORD_DEF = 32;

  // Field and register widths
  localparam int OFF_W      = 12;
  localparam int IDX_OUT_W  = 10;
  localparam int SHIFT_W    = 4;
  localparam int USABLE_W   = 13;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 13;

  // Register reset values
  localparam logic [SHIFT_W-1:0]  SLOT_SIZE_LOG2_RST = 4'd1;
  localparam logic [USABLE_W-1:0] USABLE_BYTES_RST   = 13'd3948;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SLOT_SIZE_LOG2 = 1'b0,
    CFG_USABLE_BYTES   = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_GRANTED = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_FREED   = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t             command;
    logic [OFF_W-1:0] free_offset;
  } in_t;

  typedef struct packed {
    status_t              status;
    logic [IDX_OUT_W-1:0] slot_index;
    logic [OFF_W-1:0]     byte_offset;
  } out_t;

endpackage

`default_nettype wire

@@ src/tlbsa_bitmap_ram.sv @@
// Fine bitmap store: one write port, one read port with registered read data.
// Per-word valid flops make every word read as zero until first written.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module tlbsa_bitmap_ram #(
  parameter int WORDS = 32,
  parameter int WIDTH = 32,
  localparam int ADDR_W = $clog2(WORDS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem_r [WORDS];
  logic [WORDS-1:0] vld_r;
  logic [WIDTH-1:0] rdata_r;
  logic             rvld_r;

  // Track written words; capture valid flag with each read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  // Storage array and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  // Unwritten words read as all free
  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

`default_nettype wire

@@ src/two_level_bitmap_slot_allocator.sv @@
// Two-level bitmap slot allocator: top level; uses tlbsa_pkg and tlbsa_bitmap_ram.
// Each item passes through the take, read and modify states in order, reading one
// bitmap word and writing it back through the store's single read port; no new item
// is taken until modify finishes, and modify waits while a held result is stalled.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, rst_n low): both maps clear, registers take
// slot_size_log2 = 1 and usable_bytes = 3948.
`timescale 1ns / 1ps
`default_nettype none

module two_level_bitmap_slot_allocator #(
  parameter int MAP_WORDS     = tlbsa_pkg::MAP_WORDS_DEF,
  parameter int BITS_PER_WORD = tlbsa_pkg::BITS_PER_WORD_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire tlbsa_pkg::in_t                      in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output tlbsa_pkg::out_t                          out_data,
  input  wire logic                                cfg_we,
  input  wire logic [tlbsa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [tlbsa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int SLOTS   = MAP_WORDS * BITS_PER_WORD;
  localparam int WORD_W  = $clog2(MAP_WORDS);
  localparam int BIT_W   = $clog2(BITS_PER_WORD);
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int OFF_W   = tlbsa_pkg::OFF_W;
  localparam int RANGE_W = OFF_W + 1;
  localparam int END_W   = IDX_W + 1 + 2 ** tlbsa_pkg::SHIFT_W;
  // Reciprocal of the word width, exact for every in-range slot index
  localparam int RCP_SH  = 24;
  localparam int RCP_W   = RCP_SH + 1;
  localparam int PROD_W  = IDX_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'((2 ** RCP_SH + BITS_PER_WORD - 1) / BITS_PER_WORD);
  localparam logic [BITS_PER_WORD-1:0] BIT_ONE = BITS_PER_WORD'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MOD
  } state_t;

  // Registers
  state_t                              state_r,    state_nxt;
  tlbsa_pkg::cmd_t                     cmd_r,      cmd_nxt;
  logic [WORD_W-1:0]                   word_r,     word_nxt;
  logic [IDX_W-1:0]                    idx_r,      idx_nxt;
  logic                                none_r,     none_nxt;
  logic [IDX_W-1:0]                    base_r,     base_nxt;
  logic [BIT_W-1:0]                    bit_r,      bit_nxt;
  logic [MAP_WORDS-1:0]                marks_r,    marks_nxt;
  logic                                out_vld_r,  out_vld_nxt;
  tlbsa_pkg::out_t                     out_data_r, out_data_nxt;
  logic [tlbsa_pkg::SHIFT_W-1:0]       slot_size_log2_r, slot_size_log2_nxt;
  logic [tlbsa_pkg::USABLE_W-1:0]      usable_bytes_r,   usable_bytes_nxt;

  // Datapath
  logic                      in_xfer;
  logic [OFF_W-1:0]          shifted;
  logic                      out_of_map;
  logic [IDX_W-1:0]          free_idx;
  logic [PROD_W-1:0]         prod;
  logic [WORD_W-1:0]         alloc_word;
  logic                      alloc_found;
  logic [IDX_W-1:0]          base;
  logic [IDX_W-1:0]          bit_diff;
  logic [BITS_PER_WORD-1:0]  rd_word;
  logic [BIT_W-1:0]          zbit;
  logic                      zfound;
  logic [IDX_W-1:0]          alloc_idx;
  logic [END_W-1:0]          end_val;
  logic                      over;
  logic                      grant;
  logic [BITS_PER_WORD-1:0]  set_word;
  logic [BITS_PER_WORD-1:0]  clr_word;
  logic                      mod_fire;
  logic                      ram_rd_en;
  logic                      ram_wr_en;
  logic [BITS_PER_WORD-1:0]  ram_wr_data;
  logic [IDX_W-1:0]          res_idx;

  assign in_xfer = in_valid && (state_r == S_IDLE);

  // Free path: byte offset to slot index, range check, word number
  assign shifted    = in_data.free_offset >> slot_size_log2_r;
  assign out_of_map = {1'b0, shifted} >= RANGE_W'(SLOTS);
  assign free_idx   = shifted[IDX_W-1:0];
  assign prod       = PROD_W'(free_idx) * PROD_W'(RCP);

  // Allocate path: lowest word without a full mark
  always_comb begin
    alloc_word  = '0;
    alloc_found = 1'b0;
    for (int i = 0; i < MAP_WORDS; i++) begin
      if (!alloc_found && !marks_r[i]) begin
        alloc_found = 1'b1;
        alloc_word  = WORD_W'(i);
      end
    end
  end

  // Word base index and bit position within the word
  assign base     = IDX_W'(word_r) * IDX_W'(BITS_PER_WORD);
  assign bit_diff = idx_r - base;

  // Lowest free bit of the word read back
  always_comb begin
    zbit   = '0;
    zfound = 1'b0;
    for (int i = 0; i < BITS_PER_WORD; i++) begin
      if (!zfound && !rd_word[i]) begin
        zfound = 1'b1;
        zbit   = BIT_W'(i);
      end
    end
  end

  // End-of-slot check against the usable byte limit
  assign alloc_idx = base_r + IDX_W'(zbit);
  assign end_val   = (END_W'(alloc_idx) + END_W'(1)) << slot_size_log2_r;
  assign over      = end_val > END_W'(usable_bytes_r);
  assign grant     = !none_r && zfound && !over;

  assign set_word = rd_word | (BIT_ONE << zbit);
  assign clr_word = rd_word & ~(BIT_ONE << bit_r);

  // Finish an item only when the output register can take its result
  assign mod_fire  = (state_r == S_MOD) && (!out_vld_r || !out_stall);
  assign ram_rd_en = (state_r == S_READ);
  assign ram_wr_en = mod_fire &&
                     ((cmd_r == tlbsa_pkg::CMD_FREE) ? !none_r : grant);
  assign ram_wr_data = (cmd_r == tlbsa_pkg::CMD_FREE) ? clr_word : set_word;
  assign res_idx     = (cmd_r == tlbsa_pkg::CMD_FREE) ? idx_r : alloc_idx;

  tlbsa_bitmap_ram #(
    .WORDS (MAP_WORDS),
    .WIDTH (BITS_PER_WORD)
  ) u_bitmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (ram_rd_en),
    .rd_addr (word_r),
    .rd_data (rd_word),
    .wr_en   (ram_wr_en),
    .wr_addr (word_r),
    .wr_data (ram_wr_data)
  );

  // Next-state logic
  always_comb begin
    state_nxt          = state_r;
    cmd_nxt            = cmd_r;
    word_nxt           = word_r;
    idx_nxt            = idx_r;
    none_nxt           = none_r;
    base_nxt           = base_r;
    bit_nxt            = bit_r;
    marks_nxt          = marks_r;
    out_vld_nxt        = out_vld_r;
    out_data_nxt       = out_data_r;
    slot_size_log2_nxt = slot_size_log2_r;
    usable_bytes_nxt   = usable_bytes_r;

    // Drop the result once its transfer completes
    if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end

    // Configuration writes
    if (cfg_we) begin
      case (tlbsa_pkg::cfg_idx_t'(cfg_addr))
        tlbsa_pkg::CFG_SLOT_SIZE_LOG2:
          slot_size_log2_nxt = cfg_wdata[tlbsa_pkg::SHIFT_W-1:0];
        tlbsa_pkg::CFG_USABLE_BYTES:
          usable_bytes_nxt = cfg_wdata[tlbsa_pkg::USABLE_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        // Take an item and pick its word
        if (in_xfer) begin
          cmd_nxt = in_data.command;
          if (in_data.command == tlbsa_pkg::CMD_FREE) begin
            word_nxt = prod[RCP_SH +: WORD_W];
            idx_nxt  = free_idx;
            none_nxt = out_of_map;
          end else begin
            word_nxt = alloc_word;
            idx_nxt  = '0;
            none_nxt = !alloc_found;
          end
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // Read the word; form its base index and the bit position to free
        base_nxt  = base;
        bit_nxt   = bit_diff[BIT_W-1:0];
        state_nxt = S_MOD;
      end
      S_MOD: begin
        // Modify, write back, update marks and load the result
        if (mod_fire) begin
          out_vld_nxt = 1'b1;
          if (cmd_r == tlbsa_pkg::CMD_FREE) begin
            if (none_r) begin
              out_data_nxt.status = tlbsa_pkg::ST_RANGE;
            end else begin
              out_data_nxt.status = tlbsa_pkg::ST_FREED;
              marks_nxt[word_r]   = 1'b0;
            end
          end else begin
            if (grant) begin
              out_data_nxt.status = tlbsa_pkg::ST_GRANTED;
              if (set_word == '1) begin
                marks_nxt[word_r] = 1'b1;
              end
            end else begin
              out_data_nxt.status = tlbsa_pkg::ST_NO_FREE;
            end
          end
          if ((cmd_r == tlbsa_pkg::CMD_FREE) ? !none_r : grant) begin
            out_data_nxt.slot_index  = tlbsa_pkg::IDX_OUT_W'(res_idx);
            out_data_nxt.byte_offset = OFF_W'(res_idx) << slot_size_log2_r;
          end else begin
            out_data_nxt.slot_index  = '0;
            out_data_nxt.byte_offset = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      marks_r          <= '0;
      out_vld_r        <= 1'b0;
      slot_size_log2_r <= tlbsa_pkg::SLOT_SIZE_LOG2_RST;
      usable_bytes_r   <= tlbsa_pkg::USABLE_BYTES_RST;
    end else begin
      state_r          <= state_nxt;
      marks_r          <= marks_nxt;
      out_vld_r        <= out_vld_nxt;
      slot_size_log2_r <= slot_size_log2_nxt;
      usable_bytes_r   <= usable_bytes_nxt;
    end
    cmd_r      <= cmd_nxt;
    word_r     <= word_nxt;
    idx_r      <= idx_nxt;
    none_r     <= none_nxt;
    base_r     <= base_nxt;
    bit_r      <= bit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ tb/two_level_bitmap_slot_allocator_tb.sv @@
// Self-checking testbench for two_level_bitmap_slot_allocator: a slot map tracker predicts
// each grant, free and error result from the accepted commands; depends on tlbsa_pkg and the RTL.
`timescale 1ns / 1ps

module two_level_bitmap_slot_allocator_tb;
  import tlbsa_pkg::*;

  localparam int MAP_WORDS      = MAP_WORDS_DEF;
  localparam int BITS_PER_WORD  = BITS_PER_WORD_DEF;
  localparam int NUM_PHASES     = 13;
  localparam int PHASE_ITEMS    = 110;
  localparam int WATCHDOG_LIMIT = 2000;

  // Tracks the slot map and register copies; holds the results due from the block
  class slot_map_tracker;
    bit [BITS_PER_WORD-1:0] slot_map [MAP_WORDS];
    bit [MAP_WORDS-1:0]     full_marks;
    bit [SHIFT_W-1:0]       slot_log2;
    bit [USABLE_W-1:0]      usable_limit;
    out_t                   due_results [$];
    int                     errors;

    function new();
      foreach (slot_map[w]) slot_map[w] = '0;
      full_marks   = '0;
      slot_log2    = SLOT_SIZE_LOG2_RST;
      usable_limit = USABLE_BYTES_RST;
      errors       = 0;
    endfunction

    function void set_reg(cfg_idx_t r, logic [CFG_DATA_W-1:0] v);
      case (r)
        CFG_SLOT_SIZE_LOG2: slot_log2 = v[SHIFT_W-1:0];
        CFG_USABLE_BYTES:   usable_limit = v[USABLE_W-1:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted command to the map and queue the result it causes
    function void note_request(in_t d);
      out_t                   e;
      longint                 idx;
      longint                 shifted;
      bit [BITS_PER_WORD-1:0] free_bits;
      int                     b;
      int                     wi;
      bit                     granted;
      e.status      = ST_NO_FREE;
      e.slot_index  = '0;
      e.byte_offset = '0;
      granted       = 1'b0;
      idx           = 0;
      if (d.command == CMD_ALLOC) begin
        // Scan non-full words for the lowest free slot; stop at the usable limit
        for (int w = 0; w < MAP_WORDS; w++) begin
          if (full_marks[w]) continue;
          free_bits = ~slot_map[w];
          if (free_bits == '0) continue;
          for (b = 0; b < BITS_PER_WORD; b++)
            if (free_bits[b]) break;
          idx = longint'(w) * BITS_PER_WORD + b;
          if (((idx + 1) << slot_log2) > usable_limit) break;
          slot_map[w][b] = 1'b1;
          if (&slot_map[w]) full_marks[w] = 1'b1;
          granted = 1'b1;
          break;
        end
        if (granted) begin
          shifted       = idx << slot_log2;
          e.status      = ST_GRANTED;
          e.slot_index  = idx[IDX_OUT_W-1:0];
          e.byte_offset = shifted[OFF_W-1:0];
        end
      end else begin
        idx = longint'(d.free_offset) >> slot_log2;
        if (idx >= MAP_WORDS * BITS_PER_WORD) begin
          e.status = ST_RANGE;
        end else begin
          // Clear the slot and its word's full mark, even if already free
          wi = int'(idx / BITS_PER_WORD);
          slot_map[wi][int'(idx % BITS_PER_WORD)] = 1'b0;
          full_marks[wi] = 1'b0;
          shifted        = idx << slot_log2;
          e.status       = ST_FREED;
          e.slot_index   = idx[IDX_OUT_W-1:0];
          e.byte_offset  = shifted[OFF_W-1:0];
        end
      end
      due_results.push_back(e);
    endfunction

    // Compare one result transfer with the oldest due result
    function void check_result(out_t got);
      out_t e;
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d slot_index %0d byte_offset %0d",
               got.status, got.slot_index, got.byte_offset);
        errors++;
        return;
      end
      e = due_results.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.slot_index !== e.slot_index) begin
        $error("slot_index: expected %0d, got %0d", e.slot_index, got.slot_index);
        errors++;
      end
      if (got.byte_offset !== e.byte_offset) begin
        $error("byte_offset: expected %0d, got %0d", e.byte_offset, got.byte_offset);
        errors++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Pick a random taken slot; return 0 when the map is empty
    function bit pick_taken(output int slot);
      int count;
      int k;
      count = 0;
      slot  = 0;
      foreach (slot_map[w]) count += $countones(slot_map[w]);
      if (count == 0) return 1'b0;
      k = $urandom_range(0, count - 1);
      for (int w = 0; w < MAP_WORDS; w++)
        for (int b = 0; b < BITS_PER_WORD; b++)
          if (slot_map[w][b]) begin
            if (k == 0) begin
              slot = w * BITS_PER_WORD + b;
              return 1'b1;
            end
            k--;
          end
      return 1'b0;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  slot_map_tracker sb;
  bit              no_idle;
  int              stall_left;
  int              idle_cycles;
  int              phase_log2 [NUM_PHASES - 1] = '{1, 7, 5, 0, 2, 8, 3, 6, 1, 4, 9, 10};
  int              phase_usable [NUM_PHASES - 1] =
                     '{3948, 4096, 4096, 600, 4096, 4096, 8191, 2000, 0, 4096, 4096, 4096};

  two_level_bitmap_slot_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drive result-side stall in bursts
  always @(negedge clk) begin
    if (no_idle) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left = idle_len();
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Drop valid and hold until every due result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic set_regs(logic [SHIFT_W-1:0] log2_val, logic [USABLE_W-1:0] usable_val);
    logic [CFG_DATA_W-1:0] word;
    drain_results();
    repeat (4) @(posedge clk);
    word = CFG_DATA_W'($urandom);
    word[SHIFT_W-1:0] = log2_val;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SLOT_SIZE_LOG2;
    cfg_wdata <= word;
    sb.set_reg(CFG_SLOT_SIZE_LOG2, word);
    @(negedge clk);
    cfg_addr  <= CFG_USABLE_BYTES;
    cfg_wdata <= usable_val;
    sb.set_reg(CFG_USABLE_BYTES, usable_val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Present one command, hold it until the transfer, then idle a random gap
  task automatic send_item(cmd_t cmd, logic [OFF_W-1:0] off);
    in_t d;
    int  gap;
    d.command     = cmd;
    d.free_offset = off;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
    sb.note_request(d);
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  initial begin
    int          alloc_pct;
    int          slot;
    longint      tmp;
    cmd_t        cmd;
    logic [11:0] off;
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    no_idle     = 1'b0;
    stall_left  = 0;
    idle_cycles = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: grants, re-grant of a freed slot, double free, out-of-range offsets
    send_item(CMD_ALLOC, 12'h000);
    send_item(CMD_ALLOC, 12'h5A5);
    send_item(CMD_ALLOC, 12'hA5A);
    send_item(CMD_FREE, 12'd2);
    send_item(CMD_FREE, 12'd3);
    send_item(CMD_ALLOC, 12'h000);
    send_item(CMD_FREE, 12'hFFF);
    send_item(CMD_FREE, 12'd2048);
    send_item(CMD_FREE, 12'd2046);
    send_item(CMD_ALLOC, 12'hFFF);

    // Zero slot size and zero usable bytes: nothing fits
    set_regs(4'd0, 13'd0);
    send_item(CMD_ALLOC, 12'h000);
    send_item(CMD_FREE, 12'd1023);
    send_item(CMD_FREE, 12'd1024);

    // One slot filling the whole page
    set_regs(4'd12, 13'd4096);
    send_item(CMD_ALLOC, 12'h000);
    send_item(CMD_FREE, 12'h000);
    send_item(CMD_ALLOC, 12'h000);
    send_item(CMD_ALLOC, 12'h000);

    // Slot size beyond the page
    set_regs(4'd15, 13'd8191);
    send_item(CMD_ALLOC, 12'h000);
    send_item(CMD_FREE, 12'hFFF);
    send_item(CMD_ALLOC, 12'h000);

    // Four large slots per page: grants of the first ones and a free inside the last slot
    set_regs(4'd10, 13'd4096);
    send_item(CMD_ALLOC, 12'h000);
    send_item(CMD_FREE, 12'd3077);
    send_item(CMD_ALLOC, 12'h000);
    send_item(CMD_ALLOC, 12'h000);

    // Random phases: allocations mixed with frees of taken slots and stray offsets
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1)
        set_regs(SHIFT_W'($urandom_range(0, 15)), USABLE_W'($urandom_range(0, 8191)));
      else
        set_regs(SHIFT_W'(phase_log2[p]), USABLE_W'(phase_usable[p]));
      alloc_pct = $urandom_range(45, 85);
      no_idle   = (p % 5 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain_results();
        off = 12'($urandom);
        if ($urandom_range(0, 99) < alloc_pct) begin
          cmd = CMD_ALLOC;
        end else begin
          cmd = CMD_FREE;
          if ($urandom_range(0, 4) != 0 && sb.pick_taken(slot)) begin
            tmp = (longint'(slot) << sb.slot_log2) |
                  (longint'($urandom) & ((longint'(1) << sb.slot_log2) - 1));
            off = tmp[11:0];
          end
        end
        send_item(cmd, off);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (sb.pending() != 0) $error("%0d results never arrived", sb.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ two_level_bitmap_slot_allocator.f @@
src/tlbsa_pkg.sv
src/tlbsa_bitmap_ram.sv
src/two_level_bitmap_slot_allocator.sv
tb/two_level_bitmap_slot_allocator_tb.sv
